// ===== src/srt_pkg.sv =====
// Package with the constants shared by the sorted region table files.
`timescale 1ns / 1ps
`default_nettype none
package srt_pkg;

  // Page geometry.
  localparam int PAGE_SHIFT = 12;

  // Operation codes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_FREE   = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_OVERLAP   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

endpackage
`default_nettype wire

// ===== src/srt_req_if.sv =====
// Request channel interface of the sorted region table.
`timescale 1ns / 1ps
`default_nettype none
interface srt_req_if #(
  parameter int ADDR_BITS = 48,
  parameter int FLAG_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ADDR_BITS-1:0] range_start;
  logic [ADDR_BITS:0]   range_end;
  logic [ADDR_BITS:0]   length;
  logic [FLAG_BITS-1:0] flags;

  modport source (output valid, mode, range_start, range_end, length, flags, input ready);
  modport sink (input valid, mode, range_start, range_end, length, flags, output ready);
endinterface
`default_nettype wire

// ===== src/srt_rsp_if.sv =====
// Response channel interface of the sorted region table.
`timescale 1ns / 1ps
`default_nettype none
interface srt_rsp_if #(
  parameter int ADDR_BITS  = 48,
  parameter int FLAG_BITS  = 8,
  parameter int COUNT_BITS = 7
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [ADDR_BITS-1:0]  found_start;
  logic [ADDR_BITS:0]    found_end;
  logic [FLAG_BITS-1:0]  found_flags;
  logic [ADDR_BITS:0]    free_address;
  logic [COUNT_BITS-1:0] region_count;

  modport source (output valid, status, found_start, found_end, found_flags, free_address,
                  region_count, input ready);
  modport sink (input valid, status, found_start, found_end, found_flags, free_address,
                region_count, output ready);
endinterface
`default_nettype wire

// ===== src/srt_table_mem.sv =====
// Region table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module srt_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 81
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/srt_out_reg.sv =====
// Output register that holds one result word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module srt_out_reg #(
  parameter int ADDR_BITS  = 48,
  parameter int FLAG_BITS  = 8,
  parameter int COUNT_BITS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  output logic                       can_load,
  input  wire logic [2:0]            status,
  input  wire logic [ADDR_BITS-1:0]  found_start,
  input  wire logic [ADDR_BITS:0]    found_end,
  input  wire logic [FLAG_BITS-1:0]  found_flags,
  input  wire logic [ADDR_BITS:0]    free_address,
  input  wire logic [COUNT_BITS-1:0] region_count,
  srt_rsp_if.source                  rsp
);

  logic valid;

  assign can_load  = !valid || rsp.ready;
  assign rsp.valid = valid;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && can_load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rsp.status       <= status;
      rsp.found_start  <= found_start;
      rsp.found_end    <= found_end;
      rsp.found_flags  <= found_flags;
      rsp.free_address <= free_address;
      rsp.region_count <= region_count;
    end
  end

endmodule
`default_nettype wire

// ===== src/sorted_region_table_core.sv =====
// Top level of the sorted region table: sequencer around the region memory.
//
// The block keeps up to TABLE_ENTRIES page-aligned regions, sorted by start,
// in one memory. A request word on req carries mode, range, length and flags;
// each request gives exactly one response word on rsp with status, the found
// region, the free address and the region count after the operation.
// Requests are taken one at a time: req.ready is high while the sequencer is
// idle. The sequencer walks the memory one entry at a time (read, then
// compare), and slot opening or closing moves one entry per read and write.
// The result sits in an output register, so a stalled receiver holds the
// result word while the next request is already being worked on; the
// sequencer waits only when a second result is ready before the first left.
// Reset empties the table at once by clearing the region count; the memory
// itself is not cleared, since entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_region_table_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 48,
  parameter int FLAG_BITS     = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  srt_req_if.sink   req,
  srt_rsp_if.source rsp
);
  import srt_pkg::*;

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int SPW = ADDR_BITS - PAGE_SHIFT;
  localparam int EPW = ADDR_BITS + 1 - PAGE_SHIFT;
  localparam int EW  = SPW + EPW + FLAG_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef struct packed {
    logic [SPW-1:0]       s;
    logic [EPW-1:0]       e;
    logic [FLAG_BITS-1:0] f;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_INS_DECIDE,
    S_OPEN_RD, S_OPEN_WR, S_WRITE_NEW, S_CLOSE_RD, S_CLOSE_WR, S_DONE
  } state_t;

  state_t               state;
  logic [1:0]           mode;
  logic [ADDR_BITS-1:0] a;
  logic [ADDR_BITS:0]   e_in;
  logic [ADDR_BITS:0]   len;
  logic [FLAG_BITS-1:0] fl;
  logic [CW-1:0]        held, i, w, k, lo;
  entry_t               prev, next;
  logic                 has_prev, has_next;
  logic [EPW-1:0]       srch;
  logic [2:0]           res_status;
  logic [ADDR_BITS-1:0] res_fs;
  logic [ADDR_BITS:0]   res_fe;
  logic [FLAG_BITS-1:0] res_ff;
  logic [ADDR_BITS:0]   res_fa;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  entry_t               wr_data;
  logic [IW-1:0]        rd_addr;
  logic [EW-1:0]        rd_raw;
  entry_t               d;
  logic                 out_load, can_load;

  // Derived request values.
  logic [SPW-1:0] sp;
  logic [EPW-1:0] ep;
  logic           bad;
  logic           ov, left, right, mprev, mnext;
  logic [EPW-1:0] diff;

  assign d  = entry_t'(rd_raw);
  assign sp = a[ADDR_BITS-1:PAGE_SHIFT];
  assign ep = e_in[ADDR_BITS:PAGE_SHIFT];
  assign bad = ({1'b0, a} >= e_in) || (a[PAGE_SHIFT-1:0] != '0) ||
               (e_in[PAGE_SHIFT-1:0] != '0) ||
               (e_in[ADDR_BITS] && (e_in[ADDR_BITS-1:0] != '0));
  assign ov    = !((d.e <= {1'b0, sp}) || ({1'b0, d.s} >= ep));
  assign left  = d.s < sp;
  assign right = d.e > ep;
  assign mprev = has_prev && (prev.e == {1'b0, sp}) && (prev.f == fl);
  assign mnext = has_next && ({1'b0, next.s} == ep) && (next.f == fl);
  assign diff  = {1'b0, d.s} - srch;

  assign req.ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE);

  // Read address for the current sequencer step.
  always_comb begin
    case (state)
      S_OPEN_RD:  rd_addr = IW'(k - CW'(1));
      S_CLOSE_RD: rd_addr = IW'(k + CW'(1));
      default:    rd_addr = i[IW-1:0];
    endcase
  end

  // Sequencer: state, table bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      wr_en <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode  <= req.mode;
            a     <= req.range_start;
            e_in  <= req.range_end;
            len   <= req.length;
            fl    <= req.flags;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_status <= ST_OK;
          res_fs     <= '0;
          res_fe     <= '0;
          res_ff     <= '0;
          res_fa     <= '0;
          i          <= '0;
          w          <= '0;
          has_prev   <= 1'b0;
          has_next   <= 1'b0;
          srch       <= {1'b0, a[ADDR_BITS-1:PAGE_SHIFT]} +
                        EPW'(a[PAGE_SHIFT-1:0] != '0);
          state      <= S_SCAN_RD;
          case (mode)
            MODE_INSERT, MODE_REMOVE: begin
              if (bad) begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end
            end
            MODE_FIND: begin
              res_status <= ST_NOT_FOUND;
            end
            default: begin
              if (len == '0) begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end
            end
          endcase
        end
        S_SCAN_RD: begin
          // End of the table reached.
          if (i == held) begin
            case (mode)
              MODE_INSERT: state <= S_INS_DECIDE;
              MODE_REMOVE: begin
                held  <= w;
                state <= S_DONE;
              end
              MODE_FIND: state <= S_DONE;
              default: begin
                res_fa <= {srch, {PAGE_SHIFT{1'b0}}};
                state  <= S_DONE;
              end
            endcase
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          i     <= i + CW'(1);
          state <= S_SCAN_RD;
          case (mode)
            MODE_INSERT: begin
              if (left) begin
                prev     <= d;
                has_prev <= 1'b1;
              end else begin
                next     <= d;
                has_next <= 1'b1;
                i        <= i;
                state    <= S_INS_DECIDE;
              end
            end
            MODE_REMOVE: begin
              wr_addr <= w[IW-1:0];
              if (!ov) begin
                wr_en   <= 1'b1;
                wr_data <= d;
                w       <= w + CW'(1);
              end else if (left && right) begin
                // Split: the only overlapping region, and no deletion came before.
                if (held >= FULL_COUNT) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  wr_en   <= 1'b1;
                  wr_data <= '{s: d.s, e: {1'b0, sp}, f: d.f};
                  next    <= '{s: ep[SPW-1:0], e: d.e, f: d.f};
                  lo      <= i + CW'(1);
                  k       <= held;
                  state   <= S_OPEN_RD;
                end
              end else if (left) begin
                wr_en   <= 1'b1;
                wr_data <= '{s: d.s, e: {1'b0, sp}, f: d.f};
                w       <= w + CW'(1);
              end else if (right) begin
                wr_en   <= 1'b1;
                wr_data <= '{s: ep[SPW-1:0], e: d.e, f: d.f};
                w       <= w + CW'(1);
              end
            end
            MODE_FIND: begin
              if (d.s > sp) begin
                state <= S_DONE;
              end else if ({1'b0, sp} < d.e) begin
                res_status <= ST_OK;
                res_fs     <= {d.s, {PAGE_SHIFT{1'b0}}};
                res_fe     <= {d.e, {PAGE_SHIFT{1'b0}}};
                res_ff     <= d.f;
                state      <= S_DONE;
              end
            end
            default: begin
              if (({1'b0, d.s} > srch) && ({diff, {PAGE_SHIFT{1'b0}}} >= len)) begin
                res_fa <= {srch, {PAGE_SHIFT{1'b0}}};
                state  <= S_DONE;
              end else if (d.e > srch) begin
                srch <= d.e;
              end
            end
          endcase
        end
        S_INS_DECIDE: begin
          state <= S_DONE;
          if ((has_prev && (prev.e > {1'b0, sp})) || (has_next && ({1'b0, next.s} < ep))) begin
            res_status <= ST_OVERLAP;
          end else if (mprev && mnext) begin
            wr_en   <= 1'b1;
            wr_addr <= IW'(i - CW'(1));
            wr_data <= '{s: prev.s, e: next.e, f: prev.f};
            k       <= i;
            state   <= S_CLOSE_RD;
          end else if (mprev) begin
            wr_en   <= 1'b1;
            wr_addr <= IW'(i - CW'(1));
            wr_data <= '{s: prev.s, e: ep, f: prev.f};
          end else if (mnext) begin
            wr_en   <= 1'b1;
            wr_addr <= i[IW-1:0];
            wr_data <= '{s: sp, e: next.e, f: next.f};
          end else if (held >= FULL_COUNT) begin
            res_status <= ST_FULL;
          end else begin
            next  <= '{s: sp, e: ep, f: fl};
            lo    <= i;
            k     <= held;
            state <= S_OPEN_RD;
          end
        end
        // Open a slot at lo by moving entries up from the top.
        S_OPEN_RD: begin
          state <= (k == lo) ? S_WRITE_NEW : S_OPEN_WR;
        end
        S_OPEN_WR: begin
          wr_en   <= 1'b1;
          wr_addr <= k[IW-1:0];
          wr_data <= d;
          k       <= k - CW'(1);
          state   <= S_OPEN_RD;
        end
        S_WRITE_NEW: begin
          wr_en   <= 1'b1;
          wr_addr <= lo[IW-1:0];
          wr_data <= next;
          held    <= held + CW'(1);
          state   <= S_DONE;
        end
        // Close the slot at k by moving entries down.
        S_CLOSE_RD: begin
          if ((k + CW'(1)) >= held) begin
            held  <= held - CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_CLOSE_WR;
          end
        end
        S_CLOSE_WR: begin
          wr_en   <= 1'b1;
          wr_addr <= k[IW-1:0];
          wr_data <= d;
          k       <= k + CW'(1);
          state   <= S_CLOSE_RD;
        end
        S_DONE: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  srt_table_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  srt_out_reg #(
    .ADDR_BITS  (ADDR_BITS),
    .FLAG_BITS  (FLAG_BITS),
    .COUNT_BITS (CW)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .can_load     (can_load),
    .status       (res_status),
    .found_start  (res_fs),
    .found_end    (res_fe),
    .found_flags  (res_ff),
    .free_address (res_fa),
    .region_count (held),
    .rsp          (rsp)
  );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the sorted region table core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import srt_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [63:0] PAGE = 64'd4096;
  localparam logic [63:0] TOP = 64'h0001_0000_0000_0000;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [47:0] found_start;
    logic [48:0] found_end;
    logic [7:0]  found_flags;
    logic [48:0] free_address;
    logic [6:0]  region_count;
  } region_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srt_req_if req_ch ();
  srt_rsp_if rsp_ch ();

  sorted_region_table_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the region table.
  logic [35:0] shadow_lo [SLOTS];
  logic [36:0] shadow_hi [SLOTS];
  logic [7:0]  shadow_fl [SLOTS];
  int          shadow_held = 0;

  region_reply_t replies_due[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_left = 0;
  int quiet = 0;
  int words_sent = 0;
  int words_checked = 0;

  function automatic bit bad_span(logic [63:0] s, logic [63:0] e);
    return s >= e || s[11:0] != 0 || e[11:0] != 0 || e > TOP;
  endfunction

  function automatic void open_slot(int at);
    for (int k = shadow_held; k > at; k--) begin
      shadow_lo[k] = shadow_lo[k-1];
      shadow_hi[k] = shadow_hi[k-1];
      shadow_fl[k] = shadow_fl[k-1];
    end
    shadow_held++;
  endfunction

  function automatic void close_slot(int at);
    for (int k = at; k + 1 < shadow_held; k++) begin
      shadow_lo[k] = shadow_lo[k+1];
      shadow_hi[k] = shadow_hi[k+1];
      shadow_fl[k] = shadow_fl[k+1];
    end
    shadow_held--;
  endfunction

  function automatic logic [2:0] add_region(logic [63:0] s, logic [63:0] e, logic [7:0] fl);
    logic [63:0] sp;
    logic [63:0] ep;
    int i;
    bit has_prev;
    bit has_next;
    bit join_prev;
    bit join_next;
    if (bad_span(s, e)) return ST_INVALID;
    sp = s >> PAGE_SHIFT;
    ep = e >> PAGE_SHIFT;
    i = 0;
    while (i < shadow_held && shadow_lo[i] < sp) i++;
    has_prev = i > 0;
    has_next = i < shadow_held;
    if (has_prev && shadow_hi[i-1] > sp) return ST_OVERLAP;
    if (has_next && shadow_lo[i] < ep) return ST_OVERLAP;
    join_prev = has_prev && shadow_hi[i-1] == sp && shadow_fl[i-1] == fl;
    join_next = has_next && shadow_lo[i] == ep && shadow_fl[i] == fl;
    if (join_prev && join_next) begin
      shadow_hi[i-1] = shadow_hi[i];
      close_slot(i);
    end else if (join_prev) begin
      shadow_hi[i-1] = ep;
    end else if (join_next) begin
      shadow_lo[i] = sp;
    end else begin
      if (shadow_held >= SLOTS) return ST_FULL;
      open_slot(i);
      shadow_lo[i] = sp;
      shadow_hi[i] = ep;
      shadow_fl[i] = fl;
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] cut_range(logic [63:0] s, logic [63:0] e);
    logic [63:0] sp;
    logic [63:0] ep;
    logic [36:0] old_hi;
    int i;
    if (bad_span(s, e)) return ST_INVALID;
    sp = s >> PAGE_SHIFT;
    ep = e >> PAGE_SHIFT;
    // A split needs a free slot, so a full table refuses it up front.
    if (shadow_held >= SLOTS)
      for (i = 0; i < shadow_held; i++)
        if (shadow_lo[i] < sp && shadow_hi[i] > ep) return ST_FULL;
    i = 0;
    while (i < shadow_held) begin
      if (shadow_hi[i] <= sp || shadow_lo[i] >= ep) begin
        i++;
      end else if (shadow_lo[i] < sp && shadow_hi[i] > ep) begin
        old_hi = shadow_hi[i];
        open_slot(i + 1);
        shadow_hi[i] = sp;
        shadow_lo[i+1] = ep;
        shadow_hi[i+1] = old_hi;
        shadow_fl[i+1] = shadow_fl[i];
        i += 2;
      end else if (shadow_lo[i] < sp) begin
        shadow_hi[i] = sp;
        i++;
      end else if (shadow_hi[i] > ep) begin
        shadow_lo[i] = ep;
        i++;
      end else begin
        close_slot(i);
      end
    end
    return ST_OK;
  endfunction

  function automatic region_reply_t predict_reply(logic [1:0] mode, logic [47:0] a,
                                                   logic [48:0] e, logic [48:0] len,
                                                   logic [7:0] fl);
    region_reply_t r;
    logic [63:0] rs;
    logic [63:0] re;
    logic [63:0] hunt;
    r = '{ST_OK, '0, '0, '0, '0, '0};
    case (mode)
      MODE_INSERT: r.status = add_region(a, e, fl);
      MODE_REMOVE: r.status = cut_range(a, e);
      MODE_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < shadow_held; i++) begin
          rs = 64'(shadow_lo[i]) << PAGE_SHIFT;
          re = 64'(shadow_hi[i]) << PAGE_SHIFT;
          if (rs > a) break;
          if (a < re) begin
            r.status = ST_OK;
            r.found_start = rs[47:0];
            r.found_end = re[48:0];
            r.found_flags = shadow_fl[i];
            break;
          end
        end
      end
      default: begin
        if (len == 0) begin
          r.status = ST_INVALID;
        end else begin
          // Walk the gaps from the page-rounded hint; past the last region all fits.
          hunt = (64'(a) + PAGE - 1) & ~(PAGE - 1);
          for (int i = 0; i < shadow_held; i++) begin
            rs = 64'(shadow_lo[i]) << PAGE_SHIFT;
            re = 64'(shadow_hi[i]) << PAGE_SHIFT;
            if (rs > hunt && rs - hunt >= len) break;
            else if (re > hunt) hunt = re;
          end
          r.free_address = hunt[48:0];
        end
      end
    endcase
    r.region_count = shadow_held[6:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  // Offer one request word and book its expected reply once it is taken.
  task automatic send_word(logic [1:0] mode, logic [63:0] s, logic [63:0] e,
                           logic [63:0] len, logic [7:0] fl);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.range_start = s[47:0];
    req_ch.range_end = e[48:0];
    req_ch.length = len[48:0];
    req_ch.flags = fl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    replies_due.push_back(predict_reply(mode, s[47:0], e[48:0], len[48:0], fl));
    words_sent++;
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // Receiver side: random back-pressure, or a counted hold-off.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = $urandom_range(99) >= recv_idle;
    end
  end

  // Compare each reply word with the oldest expectation.
  always @(posedge clk) begin
    region_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $display("reply word with no request outstanding");
        errors++;
      end else begin
        want = replies_due.pop_front();
        words_checked++;
        if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
        if (rsp_ch.found_start !== want.found_start)
          report("found_start", rsp_ch.found_start, want.found_start);
        if (rsp_ch.found_end !== want.found_end)
          report("found_end", rsp_ch.found_end, want.found_end);
        if (rsp_ch.found_flags !== want.found_flags)
          report("found_flags", rsp_ch.found_flags, want.found_flags);
        if (rsp_ch.free_address !== want.free_address)
          report("free_address", rsp_ch.free_address, want.free_address);
        if (rsp_ch.region_count !== want.region_count)
          report("region_count", rsp_ch.region_count, want.region_count);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("timeout with %0d replies outstanding", replies_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Basic behavior of every mode and the argument checks.
  task automatic test_modes();
    send_word(MODE_FIND, 0, 0, 0, 0);
    send_word(MODE_FREE, 0, 0, 0, 0);
    send_word(MODE_FREE, TOP - 1, 0, 1, 0);
    send_word(MODE_INSERT, PAGE, PAGE, 0, 1);
    send_word(MODE_INSERT, 1, PAGE, 0, 1);
    send_word(MODE_INSERT, 0, PAGE + 8, 0, 1);
    send_word(MODE_INSERT, TOP - PAGE, TOP + PAGE, 0, 1);
    send_word(MODE_REMOVE, 2 * PAGE, PAGE, 0, 0);
    send_word(MODE_INSERT, TOP - 4 * PAGE, TOP, 0, 8'hFF);
    send_word(MODE_INSERT, 0, PAGE, 0, 0);
    send_word(MODE_INSERT, 0, 2 * PAGE, 0, 0);
    send_word(MODE_INSERT, 4 * PAGE, 6 * PAGE, 0, 0);
    send_word(MODE_INSERT, PAGE, 2 * PAGE, 0, 0);
    send_word(MODE_INSERT, 2 * PAGE, 4 * PAGE, 0, 0);
    send_word(MODE_INSERT, 6 * PAGE, 7 * PAGE, 0, 5);
    send_word(MODE_FIND, 5 * PAGE + 3, 0, 0, 0);
    send_word(MODE_FIND, TOP - 1, 0, 0, 0);
    send_word(MODE_FREE, 1, 0, 2 * PAGE, 0);
    send_word(MODE_FREE, 0, 0, TOP, 0);
    send_word(MODE_REMOVE, 2 * PAGE, 3 * PAGE, 0, 0);
    send_word(MODE_REMOVE, 0, PAGE, 0, 0);
    send_word(MODE_REMOVE, 5 * PAGE, 8 * PAGE, 0, 0);
    send_word(MODE_REMOVE, 100 * PAGE, 101 * PAGE, 0, 0);
    send_word(MODE_REMOVE, 0, TOP, 0, 0);
    drain();
  endtask

  // Fill the table and push on it with further inserts and removes.
  task automatic test_full_table();
    for (int k = 0; k < SLOTS; k++)
      send_word(MODE_INSERT, 64'(3 * k) * PAGE, 64'(3 * k + 1) * PAGE, 0, 8'(k));
    send_word(MODE_INSERT, 500 * PAGE, 501 * PAGE, 0, 0);
    send_word(MODE_INSERT, 4 * PAGE, 5 * PAGE, 0, 7);
    send_word(MODE_INSERT, PAGE, 3 * PAGE, 0, 0);
    send_word(MODE_REMOVE, 300 * PAGE, 400 * PAGE, 0, 0);
    send_word(MODE_INSERT, 300 * PAGE, 302 * PAGE, 0, 3);
    send_word(MODE_REMOVE, 301 * PAGE, 302 * PAGE, 0, 0);
    send_word(MODE_INSERT, 301 * PAGE, 302 * PAGE, 0, 3);
    send_word(MODE_REMOVE, 0, TOP, 0, 0);
    drain();
  endtask

  // One random word: mostly well-formed work in a small window, some noise.
  task automatic send_random();
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] len;
    logic [7:0] fl;
    int pick;
    pick = $urandom_range(99);
    fl = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    s = 64'($urandom_range(200)) * PAGE;
    e = s + 64'($urandom_range(1, 12)) * PAGE;
    len = ($urandom_range(7) == 0) ? {$urandom, $urandom} & 64'h1_FFFF_FFFF_FFFF
                                   : 64'($urandom_range(0, 10)) * PAGE
                                     + 64'($urandom_range(3) == 0 ? $urandom_range(4095) : 0);
    if (pick < 10) begin
      s = {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF;
      e = {$urandom, $urandom} & 64'h0001_FFFF_FFFF_FFFF;
      if ($urandom_range(1)) e[11:0] = 0;
      if ($urandom_range(1)) s[11:0] = 0;
      send_word(2'($urandom_range(3)), s, e, len, 8'($urandom));
    end else if (pick < 50) begin
      send_word(MODE_INSERT, s, e, 0, fl);
    end else if (pick < 68) begin
      send_word(MODE_REMOVE, s, e + 64'($urandom_range(2)) * PAGE, 0, 0);
    end else if (pick < 84) begin
      send_word(MODE_FIND, s + 64'($urandom_range(4095)), 0, 0, 0);
    end else begin
      send_word(MODE_FREE, s + 64'($urandom_range(4095)), 0, len, 0);
    end
  endtask

  task automatic test_random(int count, int tx_idle, int rx_idle);
    send_idle = tx_idle;
    recv_idle = rx_idle;
    for (int n = 0; n < count; n++) send_random();
    drain();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    stall_left = 600;
    for (int n = 0; n < 20; n++) send_random();
    drain();
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_INSERT;
    req_ch.range_start = '0;
    req_ch.range_end = '0;
    req_ch.length = '0;
    req_ch.flags = '0;
    rsp_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_modes();
    test_full_table();
    test_random(180, 36, 63);
    test_random(180, 63, 36);
    test_random(180, 0, 0);
    test_backpressure();

    repeat (300) @(posedge clk);
    $display("Sent %0d request words, checked %0d replies, %0d mismatches.",
             words_sent, words_checked, errors);
    $display("Covered all four modes, argument errors, merges, splits and a full table.");
    if (errors == 0 && replies_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
